### rtl/core/ictd_pkg.sv
// Shared types and constants for the indexed chunked texture decoder.
package ictd_pkg;

  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned PAL_BASE   = 24;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned CBL_W      = 30;

  typedef enum logic [1:0] {
    KIND_PAL = 2'd0,
    KIND_HDR = 2'd1,
    KIND_PIX = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         pal_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [15:0]        width;
    logic [15:0]        height;
    logic [8:0]         fill;
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic [7:0]         val;
    logic               last;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

endpackage

### rtl/core/ictd_if.sv
// Channel interfaces for file bytes and decoded results.
interface ictd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  modport source (output valid, data_byte, file_start, input ready);
  modport sink (input valid, data_byte, file_start, output ready);
endinterface

interface ictd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  pal_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] img_width_out;
  logic [15:0] img_height_out;
  logic [8:0]  fill_index;
  logic [19:0] pixel_address;
  logic [7:0]  pixel_value;
  logic        out_of_range;
  logic        last;
  modport source (output valid, kind, pal_index, red, green, blue, img_width_out,
                  img_height_out, fill_index, pixel_address, pixel_value,
                  out_of_range, last, input ready);
  modport sink (input valid, kind, pal_index, red, green, blue, img_width_out,
                img_height_out, fill_index, pixel_address, pixel_value,
                out_of_range, last, output ready);
endinterface

### rtl/core/indexed_chunked_texture_decoder.sv
// Top level of the indexed chunked texture decoder.
//   channel   direction  payload
//   in_ch     in         data_byte, file_start
//   out_ch    out        kind, palette colour, header, pixel write, last
//   cfg_*     in         index_mode write (cfg_we, cfg_wdata)
// One byte is taken per cycle while the record queue has room; a byte that
// makes two records holds its queue entry until the result stage has taken both.
// The first record of a byte passes through the queue write, the multiply stage
// and the output register before it is offered.
// rst_n is synchronous; it clears the parser, queue and output valid.
// The record queue lets the parser run on while a result waits; input stalls when it is full.
module indexed_chunked_texture_decoder (
  input  logic       clk,
  input  logic       rst_n,
  ictd_in_if.sink    in_ch,
  ictd_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import ictd_pkg::*;

  logic   mode_r;
  logic   push, pop, nonempty, full;
  entry_t wentry, rentry;

  // Hold the index mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  ictd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .index_mode(mode_r),
    .full(full), .push(push), .entry(wentry)
  );

  ictd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(wentry), .pop(pop),
    .rdata(rentry), .nonempty(nonempty), .full(full)
  );

  ictd_back u_back (
    .clk(clk), .rst_n(rst_n), .entry(rentry), .nonempty(nonempty),
    .pop(pop), .out_ch(out_ch)
  );
endmodule

### rtl/core/ictd_front.sv
// Byte parser: tracks the file layout and builds result records.
module ictd_front (
  input  logic                clk,
  input  logic                rst_n,
  ictd_in_if.sink             in_ch,
  input  logic                index_mode,
  input  logic                full,
  output logic                push,
  output ictd_pkg::entry_t    entry
);
  import ictd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_PALETTE, PH_CHEAD, PH_CDATA, PH_IDLE
  } phase_t;

  typedef struct packed {
    logic        ok;
    res_t        res;
    logic [15:0] col;
    logic [15:0] row;
  } pix_t;

  phase_t      ph_r, ph_nxt;
  logic [23:0] off_r, off_nxt;
  logic [15:0] w_r, w_nxt, h_r, h_nxt, cl_r, cl_nxt;
  logic [15:0] ox_r, ox_nxt, oy_r, oy_nxt, cols_r, cols_nxt, rows_r, rows_nxt;
  logic [15:0] col_r, col_nxt, row_r, row_nxt;
  logic [CBL_W-1:0] cbl_r, cbl_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [8:0]  tidx_r, tidx_nxt;
  logic        tseen_r, tseen_nxt;

  logic        acc;
  logic [1:0]  cnt;
  res_t        rs0, rs1;

  // Produce one pixel write from the chunk counters, if rows remain
  function automatic pix_t emit(input logic [15:0] col, input logic [15:0] row,
                                input logic [15:0] ox, input logic [15:0] oy,
                                input logic [15:0] cols, input logic [15:0] rows,
                                input logic [7:0] v, input logic [15:0] w,
                                input logic [15:0] h);
    pix_t p;
    p = '0;
    p.col = col;
    p.row = row;
    if ($signed({2'b00, row}) < $signed({{2{rows[15]}}, rows})) begin
      p.ok         = 1'b1;
      p.res.kind   = KIND_PIX;
      p.res.val    = v;
      p.res.width  = w;
      p.res.height = h;
      p.res.px     = $signed({{2{ox[15]}}, ox}) + $signed({2'b00, col});
      p.res.py     = $signed({{2{oy[15]}}, oy}) + $signed({2'b00, row});
      p.col        = col + 16'd1;
      if ($signed({2'b00, p.col}) >= $signed({{2{cols[15]}}, cols})) begin
        p.col = '0;
        p.row = row + 16'd1;
      end
    end
    return p;
  endfunction

  assign acc          = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !full;

  always_comb begin
    logic [15:0]      wd;
    logic [23:0]      pos;
    logic [22:0]      ent;
    logic [8:0]       psz;
    logic [2:0]       hp;
    logic signed [16:0] cw, chh;
    logic [31:0]      pixels;
    res_t             r;
    pix_t             p;

    ph_nxt = ph_r; off_nxt = off_r; w_nxt = w_r; h_nxt = h_r; cl_nxt = cl_r;
    ox_nxt = ox_r; oy_nxt = oy_r; cols_nxt = cols_r; rows_nxt = rows_r;
    col_nxt = col_r; row_nxt = row_r; cbl_nxt = cbl_r; held_nxt = held_r;
    tidx_nxt = tidx_r; tseen_nxt = tseen_r;
    cnt = '0; rs0 = '0; rs1 = '0;
    wd = {held_r, in_ch.data_byte};
    pos = '0; ent = '0; hp = '0; cw = '0; chh = '0; pixels = '0; r = '0; p = '0;
    psz = index_mode ? 9'd16 : 9'd256;

    if (acc) begin
      // Restart the parser on a new file
      if (in_ch.file_start) begin
        ph_nxt = PH_HEADER; off_nxt = '0; w_nxt = '0; h_nxt = '0; cl_nxt = '0;
        ox_nxt = '0; oy_nxt = '0; cols_nxt = '0; rows_nxt = '0;
        col_nxt = '0; row_nxt = '0; cbl_nxt = '0; held_nxt = '0;
        tidx_nxt = '0; tseen_nxt = 1'b0;
      end
      wd = {held_nxt, in_ch.data_byte};

      case (ph_nxt)
        PH_HEADER: begin
          if (!off_nxt[0]) begin
            held_nxt = in_ch.data_byte;
          end else if (off_nxt == 24'd5) begin
            w_nxt = wd;
          end else if (off_nxt == 24'd7) begin
            h_nxt = wd;
          end else if (off_nxt == 24'd9) begin
            cl_nxt = wd;
          end
          if (off_nxt == 24'(PAL_BASE - 1)) ph_nxt = PH_PALETTE;
        end
        PH_PALETTE: begin
          pos = off_nxt - 24'(PAL_BASE);
          if (!pos[0]) begin
            held_nxt = in_ch.data_byte;
          end else begin
            ent = pos[23:1];
            r = '0;
            r.kind = KIND_PAL;
            r.pal_index = ent[7:0];
            r.red   = {wd[15:11], 3'b000};
            r.green = {wd[10:6], 3'b000};
            r.blue  = {wd[5:1], 3'b000};
            rs0 = r;
            cnt = 2'd1;
            if (!tseen_nxt && !wd[0]) begin
              tidx_nxt  = ent[8:0];
              tseen_nxt = 1'b1;
            end
            // Close the palette with the header record
            if (ent >= 23'(psz - 9'd1)) begin
              r = '0;
              r.kind   = KIND_HDR;
              r.width  = w_nxt;
              r.height = h_nxt;
              r.fill   = tseen_nxt ? tidx_nxt : psz;
              rs1 = r;
              cnt = 2'd2;
              if (cl_nxt == '0) begin
                ph_nxt = PH_IDLE;
              end else begin
                cl_nxt = cl_nxt - 16'd1;
                ph_nxt = PH_CHEAD;
                cbl_nxt = CBL_W'(8);
              end
            end
          end
        end
        PH_CHEAD: begin
          hp = 3'(4'd8 - cbl_nxt[3:0]);
          if (!hp[0]) begin
            held_nxt = in_ch.data_byte;
          end else if (hp == 3'd1) begin
            ox_nxt = wd;
          end else if (hp == 3'd3) begin
            oy_nxt = wd;
          end else if (hp == 3'd5) begin
            cols_nxt = wd;
          end else begin
            rows_nxt = wd;
          end
          cbl_nxt = cbl_nxt - CBL_W'(1);
          if (cbl_nxt == '0) begin
            cw  = $signed({cols_nxt[15], cols_nxt});
            chh = $signed({rows_nxt[15], rows_nxt});
            col_nxt = '0;
            row_nxt = '0;
            if (cw > 0 && chh > 0) begin
              pixels = 32'(cols_nxt[14:0] * rows_nxt[14:0]);
              cbl_nxt = index_mode ? CBL_W'((pixels + 32'd1) >> 1) : CBL_W'(pixels);
              ph_nxt = PH_CDATA;
            end else if (cl_nxt == '0) begin
              ph_nxt = PH_IDLE;
            end else begin
              cl_nxt = cl_nxt - 16'd1;
              ph_nxt = PH_CHEAD;
              cbl_nxt = CBL_W'(8);
            end
          end
        end
        PH_CDATA: begin
          if (index_mode) begin
            p = emit(col_nxt, row_nxt, ox_nxt, oy_nxt, cols_nxt, rows_nxt,
                     {4'h0, in_ch.data_byte[7:4]}, w_nxt, h_nxt);
          end else begin
            p = emit(col_nxt, row_nxt, ox_nxt, oy_nxt, cols_nxt, rows_nxt,
                     in_ch.data_byte, w_nxt, h_nxt);
          end
          col_nxt = p.col;
          row_nxt = p.row;
          if (p.ok) begin
            rs0 = p.res;
            cnt = 2'd1;
          end
          // Low nibble follows the high one in 4-bit mode
          if (index_mode) begin
            p = emit(col_nxt, row_nxt, ox_nxt, oy_nxt, cols_nxt, rows_nxt,
                     {4'h0, in_ch.data_byte[3:0]}, w_nxt, h_nxt);
            col_nxt = p.col;
            row_nxt = p.row;
            if (p.ok) begin
              if (cnt == 2'd0) begin
                rs0 = p.res;
              end else begin
                rs1 = p.res;
              end
              cnt = cnt + 2'd1;
            end
          end
          cbl_nxt = cbl_nxt - CBL_W'(1);
          if (cbl_nxt == '0) begin
            if (cl_nxt == '0) begin
              ph_nxt = PH_IDLE;
            end else begin
              cl_nxt = cl_nxt - 16'd1;
              ph_nxt = PH_CHEAD;
              cbl_nxt = CBL_W'(8);
            end
          end
        end
        default: ;
      endcase

      if (off_nxt != 24'hFFFFFF) off_nxt = off_nxt + 24'd1;
      if (cnt == 2'd2) begin
        rs1.last = 1'b1;
      end else begin
        rs0.last = 1'b1;
      end
    end
  end

  assign push      = acc && (cnt != 2'd0);
  assign entry.two = (cnt == 2'd2);
  assign entry.r0  = rs0;
  assign entry.r1  = rs1;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HEADER; off_r <= '0; w_r <= '0; h_r <= '0; cl_r <= '0;
      ox_r <= '0; oy_r <= '0; cols_r <= '0; rows_r <= '0;
      col_r <= '0; row_r <= '0; cbl_r <= '0; held_r <= '0;
      tidx_r <= '0; tseen_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; off_r <= off_nxt; w_r <= w_nxt; h_r <= h_nxt; cl_r <= cl_nxt;
      ox_r <= ox_nxt; oy_r <= oy_nxt; cols_r <= cols_nxt; rows_r <= rows_nxt;
      col_r <= col_nxt; row_r <= row_nxt; cbl_r <= cbl_nxt; held_r <= held_nxt;
      tidx_r <= tidx_nxt; tseen_r <= tseen_nxt;
    end
  end
endmodule

### rtl/core/ictd_fifo.sv
// Short queue of result records between parser and address stage.
module ictd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ictd_pkg::entry_t wdata,
  input  logic             pop,
  output ictd_pkg::entry_t rdata,
  output logic             nonempty,
  output logic             full
);
  import ictd_pkg::*;

  entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;

  assign rdata    = mem_r[rp_r];
  assign nonempty = (cnt_r != '0);
  assign full     = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
    end
  end
endmodule

### rtl/core/ictd_back.sv
// Result stage: splits entries, forms pixel addresses, drives the output.
module ictd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ictd_pkg::entry_t entry,
  input  logic             nonempty,
  output logic             pop,
  ictd_out_if.source       out_ch
);
  import ictd_pkg::*;

  logic        sub_r;
  logic        s1_v_r, s2_ready, s1_ready, take;
  res_t        s1_r, cur;
  logic [31:0] prod_r;
  logic        inr_r;
  logic        ov_r;
  res_t        o_r;
  logic [19:0] oaddr_r;
  logic        ooor_r;
  logic [32:0] a;
  logic        aoor;

  assign s2_ready = !ov_r || out_ch.ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign cur      = sub_r ? entry.r1 : entry.r0;
  assign take     = nonempty && s1_ready;
  assign pop      = take && (!entry.two || sub_r);

  // Step through the records of an entry and multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r  <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      if (take) sub_r <= entry.two && !sub_r;
      if (s1_ready) s1_v_r <= nonempty;
    end
    if (take) begin
      s1_r   <= cur;
      prod_r <= cur.py[15:0] * cur.width;
      inr_r  <= !cur.px[17] && !cur.py[17] &&
                (cur.px < $signed({2'b00, cur.width})) &&
                (cur.py < $signed({2'b00, cur.height}));
    end
  end

  assign a    = 33'(s1_r.px[15:0]) + 33'(prod_r);
  assign aoor = !inr_r || (a >= 33'(MAX_PIXELS));

  // Hold the output until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (s2_ready) begin
      ov_r <= s1_v_r;
    end
    if (s2_ready && s1_v_r) begin
      o_r     <= s1_r;
      ooor_r  <= (s1_r.kind == KIND_PIX) && aoor;
      oaddr_r <= ((s1_r.kind == KIND_PIX) && !aoor) ? a[19:0] : 20'd0;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.kind           = o_r.kind;
  assign out_ch.pal_index      = o_r.pal_index;
  assign out_ch.red            = o_r.red;
  assign out_ch.green          = o_r.green;
  assign out_ch.blue           = o_r.blue;
  assign out_ch.img_width_out  = (o_r.kind == KIND_HDR) ? o_r.width : 16'd0;
  assign out_ch.img_height_out = (o_r.kind == KIND_HDR) ? o_r.height : 16'd0;
  assign out_ch.fill_index     = o_r.fill;
  assign out_ch.pixel_address  = oaddr_r;
  assign out_ch.pixel_value    = o_r.val;
  assign out_ch.out_of_range   = ooor_r;
  assign out_ch.last           = o_r.last;
endmodule
